### design/escape_time_fractal_iterator_defines.svh
// ----------------------------------------------------------------------------
// Escape-time fractal iterator: assertion macros
// Concurrent assertion wrappers. Defining SYNTH turns them into nothing.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_DEFINES_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_DEFINES_SVH

`ifndef SYNTH

// ante holds -> cons holds in the same cycle
`define ETFI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante holds -> cons holds in the next cycle
`define ETFI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ETFI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ETFI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### design/etfi_pkg.sv
// ----------------------------------------------------------------------------
// etfi_pkg
// Widths, codes and types shared by the escape-time fractal iterator.
// ----------------------------------------------------------------------------
package etfi_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int ITER_BITS  = 16;

    localparam int C_W        = 32;               // c fields
    localparam int OP_W       = C_W + 1;          // multiplier operand
    localparam int PROD_W     = 2 * OP_W;         // multiplier product
    localparam int Z_W        = C_W + 2;          // z right after an update
    localparam int ZB_W       = FRAC_BITS + 3;    // z once known to be within 2
    localparam int D_W        = FRAC_BITS + 4;    // difference of two bounded values
    localparam int SQ_W       = 2 * FRAC_BITS + 3; // square of bounded z
    localparam int DIST_W     = 2 * FRAC_BITS + 5; // square of a difference

    localparam int STRIDE     = 20;
    localparam int STRIDE_W   = 5;

    localparam int MODE_W     = 2;
    localparam int LIMIT_W    = 16;
    localparam int EPS_W      = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int INDEX_W    = 16;
    localparam int OUTCOME_W  = 2;

    localparam logic [MODE_W-1:0] MODE_MANDEL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRICORN = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SHIP    = 2'd2;

    localparam logic [OUTCOME_W-1:0] OUT_ESCAPED  = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_LIMIT    = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_INSIDE   = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_PERIODIC = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EPS   = 2'd2;

    typedef logic signed [OP_W-1:0]   operand_t;
    typedef logic signed [PROD_W-1:0] product_t;

endpackage

### design/escape_time_fractal_iterator.sv
// ----------------------------------------------------------------------------
// Escape-time fractal iterator
// Takes one point c (signed Q4.28) and iterates z from 0 under the selected
// rule (Mandelbrot, Tricorn or Burning Ship) until escape, a periodicity hit
// or the iteration limit, then returns one result transaction. All products
// go through one registered 33x33 multiplier under a small sequencer; each
// iteration needs three products (re^2, im^2, re*im), and every 20th
// iteration also computes the distance to the saved z. In Mandelbrot mode a
// point with |c_re| < 2 and |c_im| < 2 first goes through the cardioid and
// bulb test. The next point is accepted once the result has moved to the
// output register.
// ----------------------------------------------------------------------------
`include "escape_time_fractal_iterator_defines.svh"

module escape_time_fractal_iterator (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write_en,
    input  logic [etfi_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [etfi_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [etfi_pkg::C_W-1:0]        c_re,
    input  logic signed [etfi_pkg::C_W-1:0]        c_im,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [etfi_pkg::INDEX_W-1:0]           escape_index,
    output logic [etfi_pkg::OUTCOME_W-1:0]         outcome
);

    localparam int F      = etfi_pkg::FRAC_BITS;
    localparam int OP_W   = etfi_pkg::OP_W;
    localparam int PROD_W = etfi_pkg::PROD_W;
    localparam int Z_W    = etfi_pkg::Z_W;
    localparam int ZB_W   = etfi_pkg::ZB_W;
    localparam int D_W    = etfi_pkg::D_W;
    localparam int SQ_W   = etfi_pkg::SQ_W;
    localparam int DIST_W = etfi_pkg::DIST_W;
    localparam int C_W    = etfi_pkg::C_W;
    localparam int IT_W   = etfi_pkg::ITER_BITS;
    localparam int STR_W  = etfi_pkg::STRIDE_W;

    localparam int Y2_W   = F + 2;        // c_im^2 / 2^F within the test bounds
    localparam int XS_W   = F + 3;        // x^2 / 2^F
    localparam int CIM2_W = 2 * F + 2;
    localparam int BSQ_W  = 2 * F + 4;
    localparam int BULB_W = 2 * F + 5;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CARD_Y = 4'd1;
    localparam logic [3:0] ST_CARD_X = 4'd2;
    localparam logic [3:0] ST_CARD_Q = 4'd3;
    localparam logic [3:0] ST_CARD_B = 4'd4;
    localparam logic [3:0] ST_CARD_T = 4'd5;
    localparam logic [3:0] ST_IT_AB  = 4'd6;
    localparam logic [3:0] ST_IT_NIM = 4'd7;
    localparam logic [3:0] ST_IT_RE2 = 4'd8;
    localparam logic [3:0] ST_IT_IM2 = 4'd9;
    localparam logic [3:0] ST_IT_M2  = 4'd10;
    localparam logic [3:0] ST_PD_DIM = 4'd11;
    localparam logic [3:0] ST_PD_CMP = 4'd12;
    localparam logic [3:0] ST_DONE   = 4'd13;

    localparam logic signed [C_W-1:0]  C_TWO     = C_W'(1) << (F + 1);
    localparam logic signed [C_W-1:0]  C_NEG_TWO = -C_TWO;
    localparam logic signed [Z_W-1:0]  Z_TWO     = Z_W'(1) << (F + 1);
    localparam logic signed [Z_W-1:0]  Z_NEG_TWO = -Z_TWO;
    localparam logic signed [OP_W-1:0] OP_ONE    = OP_W'(1) << F;
    localparam logic signed [OP_W-1:0] OP_QUART  = OP_W'(1) << (F - 2);
    localparam logic [SQ_W:0]          ESC_MAG2  = (SQ_W + 1)'(1) << (2 * F + 2);
    localparam logic [BULB_W-1:0]      BULB_R2   = BULB_W'(1) << (2 * F - 4);
    localparam logic [STR_W-1:0]       STR_LAST  = STR_W'(etfi_pkg::STRIDE - 1);

    // configuration
    logic [etfi_pkg::MODE_W-1:0]  fractal_mode_reg;
    logic [etfi_pkg::LIMIT_W-1:0] max_iterations_reg;
    logic [etfi_pkg::EPS_W-1:0]   period_epsilon_reg;

    // control
    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // per-point datapath
    logic [etfi_pkg::MODE_W-1:0]  mode_reg, mode_next;
    logic [etfi_pkg::LIMIT_W-1:0] limit_reg, limit_next;
    logic signed [C_W-1:0]        cre_reg, cre_next;
    logic signed [OP_W-1:0]       cim_reg, cim_next;
    logic signed [OP_W-1:0]       x_reg, x_next;
    logic signed [OP_W-1:0]       b_reg, b_next;
    logic [Y2_W-1:0]              y2_reg, y2_next;
    logic [CIM2_W-1:0]            cim2_reg, cim2_next;
    logic signed [OP_W-1:0]       q_reg, q_next;
    logic signed [OP_W-1:0]       qx_reg, qx_next;
    logic                         bulb_reg, bulb_next;
    logic signed [Z_W-1:0]        re_reg, re_next;
    logic signed [Z_W-1:0]        im_reg, im_next;
    logic signed [OP_W-1:0]       op_a_reg, op_a_next;
    logic signed [OP_W-1:0]       op_b_reg, op_b_next;
    logic signed [D_W-1:0]        dre_reg, dre_next;
    logic signed [D_W-1:0]        dim_reg, dim_next;
    logic signed [ZB_W-1:0]       sre_reg, sre_next;
    logic signed [ZB_W-1:0]       sim_reg, sim_next;
    logic [SQ_W-1:0]              re2_reg, re2_next;
    logic signed [SQ_W:0]         d2_reg, d2_next;
    logic [DIST_W-1:0]            dist_reg, dist_next;
    logic [IT_W-1:0]              iter_reg, iter_next;
    logic [STR_W-1:0]             stride_reg, stride_next;
    logic [IT_W-1:0]              res_index_reg, res_index_next;
    logic [etfi_pkg::OUTCOME_W-1:0] res_outcome_reg, res_outcome_next;
    logic [etfi_pkg::INDEX_W-1:0]   escape_index_reg, escape_index_next;
    logic [etfi_pkg::OUTCOME_W-1:0] outcome_reg, outcome_next;

    // multiplier
    etfi_pkg::operand_t mul_a;
    etfi_pkg::operand_t mul_b;
    etfi_pkg::product_t prod;

    // combinational helpers
    logic                   is_tricorn;
    logic                   is_ship;
    logic                   is_mandel;
    logic                   in_mandel;
    logic                   in_range;
    logic signed [OP_W-1:0] c_re_ext;
    logic signed [OP_W-1:0] c_im_ext;
    logic [XS_W-1:0]        xs;
    logic signed [OP_W-1:0] q_sum;
    logic [BULB_W-1:0]      bulb_sum;
    logic                   card_hit;
    logic signed [Z_W-1:0]  ab_scaled;
    logic signed [Z_W-1:0]  cim_z;
    logic signed [Z_W-1:0]  nre;
    logic signed [Z_W-1:0]  nim;
    logic                   z_out;
    logic signed [Z_W-1:0]  re_abs;
    logic signed [Z_W-1:0]  im_abs;
    logic [SQ_W-1:0]        sq;
    logic [SQ_W:0]          mag2;
    logic [DIST_W:0]        dist_sum;
    logic [DIST_W:0]        eps2;
    logic [IT_W:0]          iter_inc;
    logic                   iter_last;
    logic [STR_W-1:0]       stride_inc;

    etfi_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign is_tricorn = (mode_reg == etfi_pkg::MODE_TRICORN);
    assign is_ship    = (mode_reg == etfi_pkg::MODE_SHIP);
    assign is_mandel  = !is_tricorn && !is_ship;
    assign in_mandel  = (fractal_mode_reg != etfi_pkg::MODE_TRICORN) &&
                        (fractal_mode_reg != etfi_pkg::MODE_SHIP);
    assign in_range   = (c_re < C_TWO) && (c_re > C_NEG_TWO) &&
                        (c_im < C_TWO) && (c_im > C_NEG_TWO);
    assign c_re_ext   = OP_W'(c_re);
    assign c_im_ext   = OP_W'(c_im);

    // cardioid / bulb arithmetic
    assign xs       = prod[F +: XS_W];
    assign q_sum    = $signed(OP_W'(xs)) + $signed(OP_W'(y2_reg));
    assign bulb_sum = BULB_W'(prod[BSQ_W-1:0]) + BULB_W'(cim2_reg);
    assign card_hit = prod <= $signed(PROD_W'(y2_reg) << (F - 2));

    // z update: floor(2ab / 2^F) is floor(ab / 2^(F-1))
    assign ab_scaled = Z_W'(prod >>> (F - 1));
    assign cim_z     = Z_W'(cim_reg);
    assign nim       = is_tricorn ? (cim_z - ab_scaled) : (cim_z + ab_scaled);
    assign nre       = Z_W'(d2_reg >>> F) + Z_W'(cre_reg);

    assign z_out  = (re_reg > Z_TWO) || (re_reg < Z_NEG_TWO) ||
                    (im_reg > Z_TWO) || (im_reg < Z_NEG_TWO);
    assign re_abs = re_reg[Z_W-1] ? -re_reg : re_reg;
    assign im_abs = im_reg[Z_W-1] ? -im_reg : im_reg;

    assign sq       = prod[SQ_W-1:0];
    assign mag2     = {1'b0, re2_reg} + {1'b0, sq};
    assign dist_sum = {1'b0, dist_reg} + {1'b0, prod[DIST_W-1:0]};
    assign eps2     = (DIST_W + 1)'({period_epsilon_reg, {F{1'b0}}});

    assign iter_inc   = {1'b0, iter_reg} + (IT_W + 1)'(1);
    assign iter_last  = iter_inc >= (IT_W + 1)'(limit_reg);
    assign stride_inc = (stride_reg == STR_LAST) ? '0 : stride_reg + STR_W'(1);

    // multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_CARD_Y:
            begin
                mul_a = cim_reg;
                mul_b = cim_reg;
            end
            ST_CARD_X:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            ST_CARD_Q:
            begin
                mul_a = b_reg;
                mul_b = b_reg;
            end
            ST_CARD_B:
            begin
                mul_a = q_reg;
                mul_b = qx_reg;
            end
            ST_IT_RE2:
            begin
                mul_a = OP_W'(re_reg);
                mul_b = OP_W'(re_reg);
            end
            ST_IT_IM2:
            begin
                mul_a = OP_W'(im_reg);
                mul_b = OP_W'(im_reg);
            end
            ST_IT_M2:
            begin
                if (stride_reg == '0)
                begin
                    mul_a = OP_W'(dre_reg);
                    mul_b = OP_W'(dre_reg);
                end
                else
                begin
                    mul_a = op_a_reg;
                    mul_b = op_b_reg;
                end
            end
            ST_PD_DIM:
            begin
                mul_a = OP_W'(dim_reg);
                mul_b = OP_W'(dim_reg);
            end
            ST_IT_AB, ST_PD_CMP:
            begin
                mul_a = op_a_reg;
                mul_b = op_b_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        out_valid_next    = out_valid_reg;
        mode_next         = mode_reg;
        limit_next        = limit_reg;
        cre_next          = cre_reg;
        cim_next          = cim_reg;
        x_next            = x_reg;
        b_next            = b_reg;
        y2_next           = y2_reg;
        cim2_next         = cim2_reg;
        q_next            = q_reg;
        qx_next           = qx_reg;
        bulb_next         = bulb_reg;
        re_next           = re_reg;
        im_next           = im_reg;
        op_a_next         = op_a_reg;
        op_b_next         = op_b_reg;
        dre_next          = dre_reg;
        dim_next          = dim_reg;
        sre_next          = sre_reg;
        sim_next          = sim_reg;
        re2_next          = re2_reg;
        d2_next           = d2_reg;
        dist_next         = dist_reg;
        iter_next         = iter_reg;
        stride_next       = stride_reg;
        res_index_next    = res_index_reg;
        res_outcome_next  = res_outcome_reg;
        escape_index_next = escape_index_reg;
        outcome_next      = outcome_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next        = fractal_mode_reg;
                    limit_next       = max_iterations_reg;
                    cre_next         = c_re;
                    cim_next         = (fractal_mode_reg == etfi_pkg::MODE_SHIP) ?
                                       -c_im_ext : c_im_ext;
                    x_next           = c_re_ext - OP_QUART;
                    b_next           = c_re_ext + OP_ONE;
                    re_next          = '0;
                    im_next          = '0;
                    op_a_next        = '0;
                    op_b_next        = '0;
                    sre_next         = '0;
                    sim_next         = '0;
                    re2_next         = '0;
                    d2_next          = '0;
                    iter_next        = '0;
                    stride_next      = '0;
                    res_index_next   = '0;
                    res_outcome_next = etfi_pkg::OUT_LIMIT;
                    if (in_mandel && in_range)
                    begin
                        state_next = ST_CARD_Y;
                    end
                    else if (max_iterations_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_IT_AB;
                    end
                end
            end
            ST_CARD_Y:
            begin
                state_next = ST_CARD_X;
            end
            ST_CARD_X:
            begin
                y2_next    = prod[F +: Y2_W];
                cim2_next  = prod[CIM2_W-1:0];
                state_next = ST_CARD_Q;
            end
            ST_CARD_Q:
            begin
                q_next     = q_sum;
                qx_next    = q_sum + x_reg;
                state_next = ST_CARD_B;
            end
            ST_CARD_B:
            begin
                bulb_next  = bulb_sum <= BULB_R2;
                state_next = ST_CARD_T;
            end
            ST_CARD_T:
            begin
                if (card_hit || bulb_reg)
                begin
                    res_outcome_next = etfi_pkg::OUT_INSIDE;
                    state_next       = ST_DONE;
                end
                else if (limit_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_IT_AB;
                end
            end
            ST_IT_AB:
            begin
                state_next = ST_IT_NIM;
            end
            ST_IT_NIM:
            begin
                re_next    = nre;
                im_next    = nim;
                state_next = ST_IT_RE2;
            end
            ST_IT_RE2:
            begin
                op_a_next = OP_W'(is_ship ? re_abs : re_reg);
                op_b_next = OP_W'(is_ship ? im_abs : im_reg);
                dre_next  = D_W'(re_reg - Z_W'(sre_reg));
                dim_next  = D_W'(im_reg - Z_W'(sim_reg));
                if (z_out)
                begin
                    res_index_next   = iter_reg;
                    res_outcome_next = etfi_pkg::OUT_ESCAPED;
                    state_next       = ST_DONE;
                end
                else
                begin
                    state_next = ST_IT_IM2;
                end
            end
            ST_IT_IM2:
            begin
                re2_next   = sq;
                state_next = ST_IT_M2;
            end
            ST_IT_M2:
            begin
                d2_next = $signed({1'b0, re2_reg}) - $signed({1'b0, sq});
                if (mag2 > ESC_MAG2)
                begin
                    res_index_next   = iter_reg;
                    res_outcome_next = etfi_pkg::OUT_ESCAPED;
                    state_next       = ST_DONE;
                end
                else if (stride_reg == '0)
                begin
                    state_next = ST_PD_DIM;
                end
                else
                begin
                    // a*b for the next iteration is already issued
                    iter_next   = iter_inc[IT_W-1:0];
                    stride_next = stride_inc;
                    state_next  = iter_last ? ST_DONE : ST_IT_NIM;
                end
            end
            ST_PD_DIM:
            begin
                dist_next  = prod[DIST_W-1:0];
                state_next = ST_PD_CMP;
            end
            ST_PD_CMP:
            begin
                if (dist_sum < eps2)
                begin
                    res_outcome_next = etfi_pkg::OUT_PERIODIC;
                    state_next       = ST_DONE;
                end
                else
                begin
                    sre_next    = ZB_W'(re_reg);
                    sim_next    = ZB_W'(im_reg);
                    iter_next   = iter_inc[IT_W-1:0];
                    stride_next = stride_inc;
                    state_next  = iter_last ? ST_DONE : ST_IT_NIM;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    escape_index_next = etfi_pkg::INDEX_W'(res_index_reg);
                    outcome_next      = res_outcome_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fractal_mode_reg   <= etfi_pkg::MODE_MANDEL;
            max_iterations_reg <= etfi_pkg::LIMIT_W'(256);
            period_epsilon_reg <= etfi_pkg::EPS_W'(3);
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                etfi_pkg::REG_MODE:  fractal_mode_reg   <= cfg_data[etfi_pkg::MODE_W-1:0];
                etfi_pkg::REG_LIMIT: max_iterations_reg <= cfg_data[etfi_pkg::LIMIT_W-1:0];
                etfi_pkg::REG_EPS:   period_epsilon_reg <= cfg_data[etfi_pkg::EPS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg         <= mode_next;
        limit_reg        <= limit_next;
        cre_reg          <= cre_next;
        cim_reg          <= cim_next;
        x_reg            <= x_next;
        b_reg            <= b_next;
        y2_reg           <= y2_next;
        cim2_reg         <= cim2_next;
        q_reg            <= q_next;
        qx_reg           <= qx_next;
        bulb_reg         <= bulb_next;
        re_reg           <= re_next;
        im_reg           <= im_next;
        op_a_reg         <= op_a_next;
        op_b_reg         <= op_b_next;
        dre_reg          <= dre_next;
        dim_reg          <= dim_next;
        sre_reg          <= sre_next;
        sim_reg          <= sim_next;
        re2_reg          <= re2_next;
        d2_reg           <= d2_next;
        dist_reg         <= dist_next;
        iter_reg         <= iter_next;
        stride_reg       <= stride_next;
        res_index_reg    <= res_index_next;
        res_outcome_reg  <= res_outcome_next;
        escape_index_reg <= escape_index_next;
        outcome_reg      <= outcome_next;
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign escape_index = escape_index_reg;
    assign outcome      = outcome_reg;

    // an accepted transaction always leaves idle
    `ETFI_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall,
        state_reg != ST_IDLE, "accepted point did not start")

    // a finished result waits while the output register is still held
    `ETFI_ASSERT_NEXT(a_done_holds, clk, rst_n,
        state_reg == ST_DONE && out_valid_reg && out_stall,
        state_reg == ST_DONE, "result overwrote a stalled output")

    // the counter never reaches the limit while iterating
    `ETFI_ASSERT_IMPL(a_iter_limit, clk, rst_n,
        state_reg == ST_IT_AB || state_reg == ST_IT_NIM || state_reg == ST_IT_RE2 ||
        state_reg == ST_IT_IM2 || state_reg == ST_IT_M2 || state_reg == ST_PD_DIM ||
        state_reg == ST_PD_CMP,
        iter_reg < limit_reg, "iteration counter ran past the limit")

    // only an escape carries a nonzero index
    `ETFI_ASSERT_IMPL(a_index_zero, clk, rst_n,
        out_valid_reg && outcome_reg != etfi_pkg::OUT_ESCAPED,
        escape_index_reg == '0, "nonzero index on a non-escape result")

    // cardioid and bulb results only come from Mandelbrot mode
    `ETFI_ASSERT_IMPL(a_inside_mode, clk, rst_n,
        state_reg == ST_DONE && res_outcome_reg == etfi_pkg::OUT_INSIDE,
        is_mandel, "cardioid result outside Mandelbrot mode")

endmodule

### design/etfi_mul.sv
// ----------------------------------------------------------------------------
// etfi_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module etfi_mul (
    input  logic               clk,
    input  etfi_pkg::operand_t a,
    input  etfi_pkg::operand_t b,
    output etfi_pkg::product_t p
);

    etfi_pkg::product_t p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= etfi_pkg::PROD_W'(a) * etfi_pkg::PROD_W'(b);
    end

    assign p = p_reg;

endmodule

### tb/sv/escape_time_fractal_iterator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator_tb
// Self-checking bench for the escape-time fractal iterator. A queue-fed driver
// sends points, a local predictor works out the outcome and escape index of
// each accepted point, and a monitor checks every result transaction in order.
// Runs a directed set and then random phases under varied register settings
// and idle/stall patterns.
// ----------------------------------------------------------------------------
module escape_time_fractal_iterator_tb;

    import etfi_pkg::*;

    // unused mode code; the block treats it as Mandelbrot
    localparam logic [MODE_W-1:0] MODE_ALIAS = 2'd3;

    localparam int          ONE_Q    = 1 << FRAC_BITS;
    localparam int          C_MIN    = 32'h8000_0000;
    localparam int          C_MAX    = 32'h7fff_ffff;
    localparam int unsigned SPAN_Q   = 32'd1207959552;  // 4.5 in Q4.28
    localparam logic [EPS_W-1:0] EPS_MAX = '1;
    localparam int          PHASES   = 8;
    localparam int          PHASE_PTS = 100;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_kind_t;

    typedef struct packed {
        logic signed [C_W-1:0] re;
        logic signed [C_W-1:0] im;
    } point_t;

    typedef struct packed {
        logic [INDEX_W-1:0]   index;
        logic [OUTCOME_W-1:0] outcome;
    } point_result_t;

    typedef struct {
        point_t        c;
        point_result_t res;
    } predicted_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   in_valid     = 1'b0;
    logic                   in_stall;
    logic signed [C_W-1:0]  c_re         = '0;
    logic signed [C_W-1:0]  c_im         = '0;
    logic                   out_valid;
    logic                   out_stall    = 1'b0;
    logic [INDEX_W-1:0]     escape_index;
    logic [OUTCOME_W-1:0]   outcome;

    // local copy of the register file
    logic [MODE_W-1:0]      mode_cfg  = MODE_MANDEL;
    logic [LIMIT_W-1:0]     limit_cfg = 16'd256;
    logic [EPS_W-1:0]       eps_cfg   = 31'd3;

    point_t        points_to_send[$];
    predicted_t    predicted_results[$];
    point_t        drive_point;
    predicted_t    oldest;
    logic          in_taken        = 1'b0;
    int            sender_idle_pct = 0;
    int            recv_stall_pct  = 0;
    int            fail_count      = 0;
    int            points_accepted = 0;
    int            outcome_seen[4] = '{0, 0, 0, 0};

    escape_time_fractal_iterator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .c_re         (c_re),
        .c_im         (c_im),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .escape_index (escape_index),
        .outcome      (outcome)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic bit inside_main_bulbs(longint cre, longint cim);
        longint two, x, y2, q, b;
        two = longint'(2) << FRAC_BITS;
        if (cre >= two || cre <= -two || cim >= two || cim <= -two)
            return 1'b0;
        x  = cre - (longint'(1) << (FRAC_BITS - 2));
        y2 = (cim * cim) >>> FRAC_BITS;
        q  = ((x * x) >>> FRAC_BITS) + y2;
        if (q * (q + x) <= (y2 << (FRAC_BITS - 2)))
            return 1'b1;
        b = cre + (longint'(1) << FRAC_BITS);
        return (b * b + cim * cim) <= (longint'(1) << (2 * FRAC_BITS - 4));
    endfunction

    function automatic point_result_t predict_point(point_t c);
        longint        two, cre, cim, zr, zi, nr, ni, a, b, saved_r, saved_i;
        longint        dr, di, eps2;
        int            i;
        point_result_t r;
        two     = longint'(2) << FRAC_BITS;
        cre     = longint'($signed(c.re));
        cim     = longint'($signed(c.im));
        eps2    = longint'(eps_cfg) << FRAC_BITS;
        r.index   = '0;
        r.outcome = OUT_LIMIT;
        if (mode_cfg == MODE_MANDEL || mode_cfg == MODE_ALIAS)
        begin
            if (inside_main_bulbs(cre, cim))
            begin
                r.outcome = OUT_INSIDE;
                return r;
            end
        end
        if (mode_cfg == MODE_SHIP)
            cim = -cim;
        zr = 0;
        zi = 0;
        saved_r = 0;
        saved_i = 0;
        for (i = 0; i < int'(limit_cfg); i++)
        begin
            a = zr;
            b = zi;
            if (mode_cfg == MODE_SHIP)
            begin
                if (a < 0) a = -a;
                if (b < 0) b = -b;
            end
            nr = ((a * a - b * b) >>> FRAC_BITS) + cre;
            ni = (2 * a * b) >>> FRAC_BITS;
            if (mode_cfg == MODE_TRICORN)
                ni = -ni;
            zr = nr;
            zi = ni + cim;
            if (zr > two || zr < -two || zi > two || zi < -two ||
                zr * zr + zi * zi > (longint'(1) << (2 * FRAC_BITS + 2)))
            begin
                r.index   = i[INDEX_W-1:0];
                r.outcome = OUT_ESCAPED;
                return r;
            end
            if (i % STRIDE == 0)
            begin
                dr = zr - saved_r;
                di = zi - saved_i;
                if (dr * dr + di * di < eps2)
                begin
                    r.outcome = OUT_PERIODIC;
                    return r;
                end
                saved_r = zr;
                saved_i = zi;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: new point or idle at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (points_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                drive_point = points_to_send.pop_front();
                c_re     <= drive_point.re;
                c_im     <= drive_point.im;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // accepted points get their prediction here
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            predicted_results.push_back('{c: '{re: c_re, im: c_im},
                                          res: predict_point('{re: c_re, im: c_im})});
            points_accepted++;
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_results.size() == 0)
            begin
                $error("unexpected result transaction: escape_index %0d, outcome %0d",
                       escape_index, outcome);
                fail_count++;
            end
            else
            begin
                oldest = predicted_results.pop_front();
                if (escape_index !== oldest.res.index)
                begin
                    $error("escape_index: expected %0d, got %0d (c_re %0d, c_im %0d)",
                           oldest.res.index, escape_index,
                           $signed(oldest.c.re), $signed(oldest.c.im));
                    fail_count++;
                end
                if (outcome !== oldest.res.outcome)
                begin
                    $error("outcome: expected %0d, got %0d (c_re %0d, c_im %0d)",
                           oldest.res.outcome, outcome,
                           $signed(oldest.c.re), $signed(oldest.c.im));
                    fail_count++;
                end
                outcome_seen[oldest.res.outcome]++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_point(input int re, input int im);
        points_to_send.push_back('{re: re, im: im});
    endtask

    function automatic int edge_value();
        case ($urandom_range(7))
            0: return C_MIN;
            1: return C_MAX;
            2: return 0;
            3: return -1;
            4: return 2 * ONE_Q;
            5: return -2 * ONE_Q;
            6: return 2 * ONE_Q + 1;
            default: return -2 * ONE_Q - 1;
        endcase
    endfunction

    function automatic point_t random_point();
        point_t p;
        int     pick;
        int     base_re, base_im;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            // plain sweep over the interesting square
            p.re = $urandom_range(SPAN_Q) - SPAN_Q / 2;
            p.im = $urandom_range(SPAN_Q) - SPAN_Q / 2;
        end
        else if (pick < 80)
        begin
            // close to boundary features where orbits run long
            case ($urandom_range(5))
                0: begin base_re = -3 * ONE_Q / 4; base_im = 0;         end
                1: begin base_re = ONE_Q / 4;      base_im = 0;         end
                2: begin base_re = -2 * ONE_Q;     base_im = 0;         end
                3: begin base_re = -5 * ONE_Q / 4; base_im = 0;         end
                4: begin base_re = -ONE_Q / 8;     base_im = 3 * ONE_Q / 4; end
                default: begin base_re = -7 * ONE_Q / 4; base_im = 0; end
            endcase
            p.re = base_re + int'($urandom_range(1 << 21)) - (1 << 20);
            p.im = base_im + int'($urandom_range(1 << 21)) - (1 << 20);
        end
        else if (pick < 90)
        begin
            p.re = $urandom;
            p.im = $urandom;
        end
        else
        begin
            p.re = edge_value();
            p.im = edge_value();
        end
        return p;
    endfunction

    task automatic settle();
        while (points_to_send.size() != 0 || in_valid || predicted_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            REG_MODE:  mode_cfg  = value[MODE_W-1:0];
            REG_LIMIT: limit_cfg = value[LIMIT_W-1:0];
            REG_EPS:   eps_cfg   = value[EPS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [MODE_W-1:0] mode, input logic [LIMIT_W-1:0] limit,
                             input logic [EPS_W-1:0] eps, input idle_kind_t idling);
        settle();
        write_reg(REG_MODE, CFG_DATA_W'(mode));
        write_reg(REG_LIMIT, CFG_DATA_W'(limit));
        write_reg(REG_EPS, CFG_DATA_W'(eps));
        case (idling)
            IDLE_SENDER:   begin sender_idle_pct = 71; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  recv_stall_pct = 71; end
            IDLE_BOTH:     begin sender_idle_pct = 29; recv_stall_pct = 29; end
            default:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    initial
    begin
        int                 k, n;
        logic [MODE_W-1:0]  mode;
        logic [LIMIT_W-1:0] limit;
        logic [EPS_W-1:0]   eps;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Mandelbrot at reset values: cardioid, bulb, z = 2 fixed point,
        // c = i preperiodic orbit, quick escape, field extremes, slow cusp
        configure(MODE_MANDEL, 16'd256, 31'd3, IDLE_NONE);
        add_point(0, 0);
        add_point(-ONE_Q, 0);
        add_point(-2 * ONE_Q, 0);
        add_point(0, ONE_Q);
        add_point(ONE_Q, 0);
        add_point(C_MIN, C_MIN);
        add_point(C_MAX, C_MAX);
        add_point(C_MIN, C_MAX);
        add_point(ONE_Q / 4 + ONE_Q / 64, 0);
        add_point(-3 * ONE_Q / 4, ONE_Q / 32);

        // tiny c is caught by the first periodicity check
        configure(MODE_TRICORN, 16'd256, 31'd3, IDLE_NONE);
        add_point(1, 1);
        add_point(0, 0);
        add_point(ONE_Q / 2, ONE_Q / 2);

        configure(MODE_SHIP, 16'd64, 31'd1000, IDLE_NONE);
        add_point(-7 * ONE_Q / 4, -ONE_Q / 32);
        add_point(ONE_Q, ONE_Q);
        add_point(C_MIN, C_MAX);
        add_point(0, -ONE_Q / 2);

        configure(MODE_ALIAS, 16'd32, 31'd3, IDLE_NONE);
        add_point(0, 0);
        add_point(-ONE_Q, 0);
        add_point(ONE_Q, 0);

        // no iterations at all
        configure(MODE_MANDEL, 16'd0, 31'd0, IDLE_NONE);
        add_point(ONE_Q, ONE_Q);
        add_point(0, 0);
        add_point(C_MAX, C_MAX);

        configure(MODE_TRICORN, 16'hffff, 31'd0, IDLE_NONE);
        add_point(ONE_Q, 0);
        add_point(C_MAX, 0);

        configure(MODE_SHIP, 16'hffff, EPS_MAX, IDLE_NONE);
        add_point(ONE_Q / 2, -ONE_Q / 2);

        for (k = 0; k < PHASES; k++)
        begin
            mode  = MODE_W'(k % 4);
            limit = LIMIT_W'($urandom_range(120, 2));
            eps   = EPS_W'($urandom_range(65536, 1));
            case (k)
                0: begin limit = 16'd256; eps = 31'd3; end
                1: limit = 16'd1;
                2: eps = '0;
                // every point ends on its first iteration here
                5: begin limit = 16'hffff; eps = EPS_MAX; end
                7: eps = EPS_W'($urandom >> 1);
                default: ;
            endcase
            configure(mode, limit, eps, idle_kind_t'((k + k / 4) % 4));
            for (n = 0; n < PHASE_PTS; n++)
                points_to_send.push_back(random_point());
        end

        settle();
        repeat (50) @(negedge clk);

        $display("Summary: %0d points across all four mode codes, limits 0 to 65535,",
                 points_accepted);
        $display("  epsilon 0 to max; %0d escaped, %0d at limit, %0d inside, %0d periodic",
                 outcome_seen[OUT_ESCAPED], outcome_seen[OUT_LIMIT],
                 outcome_seen[OUT_INSIDE], outcome_seen[OUT_PERIODIC]);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #40_000_000;
        $display("timeout with %0d results outstanding", predicted_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
